// File: src/oets_pkg.sv
package oets_pkg;

    // store geometry and word width
    localparam int MAX_ELEMENTS = 64;
    localparam int VALUE_WIDTH  = 32;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]              count_t;

    // controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT_ODD,
        ST_SORT_EVEN,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // take one input word
        logic sort;       // run one compare-exchange phase
        logic odd_phase;  // 1: pairs (1,2),(3,4)..  0: pairs (0,1),(2,3)..
        logic shift_out;  // output word taken, advance the list
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic swapped;    // current phase exchanged at least one pair
        logic last_word;  // one element left in the list
    } status_t;

endpackage

// File: src/odd_even_transposition_sorter.sv
// Channel  Dir  tdata                        tlast         tuser
// s_*      in   [31:0] value                 final_item    -
// m_*      out  [31:0] sorted_value          end_of_run    [0] overflow
//
// Loading takes one cycle per word; s_tready is high only while loading.
// Sorting runs one compare-exchange phase per cycle over a row of 64 cells,
// two phases a round, until a round makes no exchange. Emission gives one
// word per cycle while m_tready is high; output stalls simply hold the word
// in cell 0.
// Reset clears the fill count, overflow flag and controller state; cell
// contents are not reset. Words beyond 64 are dropped and flagged.
module odd_even_transposition_sorter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] sorted_value
    output logic        m_tlast,
    output logic        m_tuser     // [0] overflow
);

    oets_pkg::cmd_t    cmd;
    oets_pkg::status_t status;
    oets_pkg::value_t  out_value;

    oets_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    oets_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_value     (oets_pkg::value_t'(s_tdata)),
        .out_value    (out_value),
        .out_overflow (m_tuser)
    );

    assign m_tdata = 32'(out_value);
    assign m_tlast = status.last_word;

endmodule

// File: src/oets_dp.sv
module oets_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  oets_pkg::cmd_t      cmd,
    output oets_pkg::status_t   status,
    input  oets_pkg::value_t    in_value,
    output oets_pkg::value_t    out_value,
    output logic                out_overflow
);

    localparam int N = oets_pkg::MAX_ELEMENTS;

    oets_pkg::value_t cell_reg  [N];
    oets_pkg::value_t cell_next [N];
    oets_pkg::count_t count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [N-1:0]     pair_swap;   // bit k: pair (k,k+1) exchanges this phase
    logic             full;

    assign full = (count_reg == oets_pkg::count_t'(N));

    // compare-exchange cells: pair k is live when it sits in the list and
    // matches the parity of the phase
    always_comb
    begin
        pair_swap = '0;
        for (int k = 0; k < N - 1; k++)
        begin
            if ((oets_pkg::count_t'(k + 1) < count_reg)
                && ((k % 2 == 1) == cmd.odd_phase)
                && (cell_reg[k] > cell_reg[k+1]))
            begin
                pair_swap[k] = 1'b1;
            end
        end
    end

    // next contents of the cell row
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        if (cmd.load && !full)
        begin
            // new word enters at cell 0, the rest move up
            cell_next[0] = in_value;
            for (int i = 1; i < N; i++)
            begin
                cell_next[i] = cell_reg[i-1];
            end
        end
        else if (cmd.sort)
        begin
            for (int k = 0; k < N - 1; k++)
            begin
                if (pair_swap[k])
                begin
                    cell_next[k]   = cell_reg[k+1];
                    cell_next[k+1] = cell_reg[k];
                end
            end
        end
        else if (cmd.shift_out)
        begin
            // smallest word leaves from cell 0
            for (int i = 0; i < N - 1; i++)
            begin
                cell_next[i] = cell_reg[i+1];
            end
        end
    end

    // fill count and dropped-word flag
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.load)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + oets_pkg::count_t'(1);
            end
        end
        else if (cmd.shift_out)
        begin
            count_next = count_reg - oets_pkg::count_t'(1);
            if (count_reg == oets_pkg::count_t'(1))
            begin
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    assign status.swapped   = |pair_swap;
    assign status.last_word = (count_reg == oets_pkg::count_t'(1));
    assign out_value        = cell_reg[0];
    assign out_overflow     = ovf_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= oets_pkg::count_t'(N))
        else $error("fill count beyond store size");

    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_out |-> (count_reg != '0))
        else $error("output shift on empty list");

    a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && full) |=> (ovf_reg && count_reg == oets_pkg::count_t'(N)))
        else $error("dropped word not flagged");

    a_sort_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sort |=> $stable(count_reg))
        else $error("fill count moved during sort");
`endif

endmodule

// File: src/oets_ctrl.sv
module oets_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output oets_pkg::cmd_t      cmd,
    input  oets_pkg::status_t   status
);

    oets_pkg::state_t state_reg, state_next;
    logic             swap_reg, swap_next;   // odd phase of this round swapped

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oets_pkg::ST_LOAD;
            swap_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            swap_reg  <= swap_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        swap_next  = swap_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            oets_pkg::ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tlast)
                    begin
                        state_next = oets_pkg::ST_SORT_ODD;
                    end
                end
            end
            oets_pkg::ST_SORT_ODD:
            begin
                cmd.sort      = 1'b1;
                cmd.odd_phase = 1'b1;
                swap_next     = status.swapped;
                state_next    = oets_pkg::ST_SORT_EVEN;
            end
            oets_pkg::ST_SORT_EVEN:
            begin
                cmd.sort = 1'b1;
                // a round without any exchange ends the sort
                if (swap_reg || status.swapped)
                begin
                    state_next = oets_pkg::ST_SORT_ODD;
                end
                else
                begin
                    state_next = oets_pkg::ST_EMIT;
                end
            end
            oets_pkg::ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    cmd.shift_out = 1'b1;
                    if (status.last_word)
                    begin
                        state_next = oets_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = oets_pkg::ST_LOAD;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output open together");

    a_last_to_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == oets_pkg::ST_SORT_ODD))
        else $error("closing word did not start the sort");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && status.last_word) |=> s_tready)
        else $error("list end did not reopen input");
`endif

endmodule

// File: verif/sorted_run_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of the sorter, rebuilds each loaded list,
// sorts it the same way the block does and compares every output word.
module sorted_run_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [31:0] sorted_value
    input  logic        m_tlast,
    input  logic        m_tuser,    // [0] overflow
    output int          mismatch_count,
    output int          words_waiting
);

    typedef struct packed {
        oets_pkg::value_t sorted_val;
        logic             run_end;
        logic             dropped;
    } sorted_word_t;

    // list under construction
    oets_pkg::value_t list_vals [oets_pkg::MAX_ELEMENTS];
    int               list_len;
    logic             list_dropped;

    // sorted words still owed by the block, oldest first
    sorted_word_t sorted_words_q [$];

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // odd phase, then even phase, until a whole round exchanges nothing
    task automatic transpose_sort();
        logic             exchanged;
        oets_pkg::value_t tmp;
        exchanged = 1'b1;
        while (exchanged)
        begin
            exchanged = 1'b0;
            for (int start = 1; start >= 0; start--)
            begin
                for (int k = start; k + 1 < list_len; k += 2)
                begin
                    if (list_vals[k] > list_vals[k+1])
                    begin
                        tmp            = list_vals[k];
                        list_vals[k]   = list_vals[k+1];
                        list_vals[k+1] = tmp;
                        exchanged      = 1'b1;
                    end
                end
            end
        end
    endtask

    // sort the finished list and queue one word per element
    task automatic close_list();
        sorted_word_t w;
        transpose_sort();
        for (int i = 0; i < list_len; i++)
        begin
            w.sorted_val = list_vals[i];
            w.run_end    = (i == list_len - 1);
            w.dropped    = list_dropped;
            sorted_words_q.push_back(w);
        end
        list_len     = 0;
        list_dropped = 1'b0;
    endtask

    always @(posedge clk)
    begin
        sorted_word_t want;
        if (!rst_n)
        begin
            list_len       = 0;
            list_dropped   = 1'b0;
            mismatch_count = 0;
            sorted_words_q.delete();
        end
        else
        begin
            // input word: store or drop when full
            if (s_tvalid && s_tready)
            begin
                if (list_len < oets_pkg::MAX_ELEMENTS)
                begin
                    list_vals[list_len] = oets_pkg::value_t'(s_tdata);
                    list_len++;
                end
                else
                begin
                    list_dropped = 1'b1;
                end
                if (s_tlast)
                    close_list();
            end
            // output word: compare against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (sorted_words_q.size() == 0)
                begin
                    flag_mismatch("unexpected word", m_tdata, 32'h0);
                end
                else
                begin
                    want = sorted_words_q.pop_front();
                    if (m_tdata !== want.sorted_val)
                        flag_mismatch("sorted_value", m_tdata, want.sorted_val);
                    if (m_tlast !== want.run_end)
                        flag_mismatch("end_of_run", {31'b0, m_tlast}, {31'b0, want.run_end});
                    if (m_tuser !== want.dropped)
                        flag_mismatch("overflow", {31'b0, m_tuser}, {31'b0, want.dropped});
                end
            end
        end
        words_waiting = sorted_words_q.size();
    end

endmodule

// File: verif/odd_even_transposition_sorter_tb.sv
`timescale 1ns / 100ps

module odd_even_transposition_sorter_tb;

    localparam int RANDOM_WORDS = 270;
    localparam int CALM_FROM    = 230;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 2 * oets_pkg::MAX_ELEMENTS + 16;
    localparam int CYCLE_LIMIT  = 60000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;     // [31:0] value
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [31:0] sorted_value
    logic        m_tlast;
    logic        m_tuser;     // [0] overflow

    int   mismatch_count;
    int   words_waiting;
    int   cycle_count;
    int   random_sent;
    logic calm;
    logic hold_armed;
    logic hold_done;

    odd_even_transposition_sorter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    sorted_run_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .words_waiting  (words_waiting)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // offer one word, with an occasional gap ahead of it
    task automatic send_word(input logic [31:0] v, input logic last);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // mix of extremes, near-duplicates and full-range values
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($signed($urandom_range(0, 7)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_list(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_word(pick_value(), i == len - 1);
            random_sent++;
            if (random_sent >= CALM_FROM)
                calm <= 1'b1;
        end
    endtask

    // receiver: random stalls, one long hold-off while a run is pending
    initial
    begin
        int stall;
        hold_done <= 1'b0;
        m_tready  <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_armed && !hold_done && m_tvalid)
            begin
                m_tready  <= 1'b0;
                hold_done <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 6);
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int list_no;
        int len;
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 32'h0;
        s_tlast     <= 1'b0;
        calm        <= 1'b0;
        hold_armed  <= 1'b0;
        random_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-element list
        send_word(32'h0000_0005, 1'b1);
        // extremes in mixed order
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h8000_0001, 1'b1);
        // already ascending
        send_word(32'hFFFF_FFFD, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0002, 1'b0);
        send_word(32'h0000_0009, 1'b1);
        // strictly descending
        send_word(32'd40, 1'b0);
        send_word(32'd30, 1'b0);
        send_word(32'd20, 1'b0);
        send_word(32'd10, 1'b0);
        send_word(32'hFFFF_FFF6, 1'b1);
        // repeated values
        send_word(32'd7, 1'b0);
        send_word(32'd7, 1'b0);
        send_word(32'hFFFF_FFF9, 1'b0);
        send_word(32'd7, 1'b1);
        // two words out of order
        send_word(32'd1, 1'b0);
        send_word(32'd0, 1'b1);

        // random lists; one exactly full, one overflowing past the last word
        hold_armed <= 1'b1;
        list_no = 0;
        while (random_sent < RANDOM_WORDS || list_no <= 7)
        begin
            if (list_no == 3)
                len = oets_pkg::MAX_ELEMENTS;
            else if (list_no == 7)
                len = oets_pkg::MAX_ELEMENTS + 3;
            else
                len = $urandom_range(1, 10);
            send_random_list(len);
            list_no++;
        end
        s_tvalid <= 1'b0;

        // drain
        while (words_waiting != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && words_waiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
